FILE: rtl/cpt_pkg.sv
package cpt_pkg;

  localparam logic [1:0] OP_TRIGGER = 2'd0;
  localparam logic [1:0] OP_STAGE   = 2'd1;
  localparam logic [1:0] OP_ARM     = 2'd2;

  localparam logic [1:0] CFG_PAD_SEL   = 2'd0;
  localparam logic [1:0] CFG_GLOBAL_CH = 2'd1;

  localparam logic [4:0] GLOBAL_SEL  = 5'h10;
  localparam logic [7:0] NOTE_UNUSED = 8'hff;
  localparam logic [39:0] SEL_RESET  = 40'd567489872400;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] pad;
    logic [6:0] velocity;
    logic       rescale;
    logic [2:0] slot;
    logic [7:0] slot_note;
    logic [7:0] slot_velocity;
    logic [3:0] commit_count;
  } cpt_in_t;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] note;
    logic [7:0] note_velocity;
    logic       last;
  } cpt_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COMMIT_RD,
    ST_COMMIT_WR,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_DATA,
    ST_DIV,
    ST_OUT
  } cpt_state_t;

endpackage

FILE: rtl/chord_pad_trigger.sv
// A note-on trigger while armed commits the staged slots to the pad, reading and then
// writing each slot. Otherwise a note-on trigger scans the pad's slots, then reads each
// active note, runs a bit-serial divider per rescaled note, and waits for each word to be
// taken. A note-off reads and emits each active note. Input is taken only when idle, so
// one input word is handled at a time. Reset is synchronous and active low; it clears
// control state, counts, staging slots and the per-entry valid bits of the chord memory.
module chord_pad_trigger #(
  parameter int PAD_COUNT     = 8,
  parameter int SLOTS_PER_PAD = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpt_pkg::cpt_in_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output cpt_pkg::cpt_out_t out_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [39:0]       cfg_wdata
);
  import cpt_pkg::*;

  localparam int SW    = (SLOTS_PER_PAD > 1) ? $clog2(SLOTS_PER_PAD) : 1;
  localparam int CW    = $clog2(SLOTS_PER_PAD + 1);
  localparam int PW    = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int DEPTH = PAD_COUNT * SLOTS_PER_PAD;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS_PER_PAD);

  cpt_state_t state_r, state_nxt;

  logic [39:0]   sel_r;
  logic [3:0]    gch_r;
  logic [15:0]   stage_r [SLOTS_PER_PAD];
  logic [3:0]    pend_cnt_r;
  logic          armed_r;
  logic [CW-1:0] act_cnt_r [PAD_COUNT];

  logic [15:0]   chord_mem [DEPTH];
  logic [14:0]   act_mem [DEPTH];
  logic          cvalid_r [DEPTH];
  logic [15:0]   chord_q;
  logic          cvq;
  logic [14:0]   act_q;

  logic [AW-1:0] base_r;
  logic [PW-1:0] pad_r;
  logic [3:0]    ch_r;
  logic [6:0]    vel_r;
  logic          noff_r;
  logic          resc_r;
  logic          rescale_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] ccnt_r;
  logic          rpend_r;
  logic [7:0]    max_r;
  logic [14:0]   num_r;
  logic [7:0]    rem_r;
  logic [3:0]    dcnt_r;
  logic [6:0]    note_r;
  logic [7:0]    ovel_r;

  logic          accept;
  logic          pad_ok;
  logic [PW-1:0] in_pad;
  logic [4:0]    in_sel;
  logic [15:0]   chord_rd;
  logic          scan_done;
  logic          last_w;

  logic          c_we;
  logic [AW-1:0] c_waddr;
  logic [15:0]   c_wdata;
  logic [AW-1:0] c_raddr;
  logic          a_we;
  logic [AW-1:0] a_waddr;
  logic [14:0]   a_wdata;
  logic [AW-1:0] a_raddr;

  logic [7:0]    vclamp;
  logic [8:0]    rem_sh;
  logic [7:0]    den;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign pad_ok   = int'(in_word.pad) < PAD_COUNT;
  assign in_pad   = PW'(in_word.pad);
  assign in_sel   = sel_r[in_word.pad*5 +: 5];
  assign chord_rd = cvq ? chord_q : 16'h0000;
  assign scan_done = (idx_r == SLOTS_C) && !rpend_r;
  assign last_w   = ((idx_r + CW'(1)) == n_r);
  assign den      = max_r - 8'd1;
  assign rem_sh   = {rem_r, num_r[14]};
  assign vclamp   = (act_q[14:7] == 8'd0) ? 8'd1 : act_q[14:7];

  assign out_valid = (state_r == ST_OUT);
  assign out_word  = '{channel: ch_r, note: note_r, note_velocity: ovel_r, last: last_w};

  always_comb begin
    state_nxt = state_r;
    c_we      = 1'b0;
    c_waddr   = AW'(base_r + AW'(idx_r));
    c_wdata   = stage_r[idx_r[SW-1:0]];
    c_raddr   = AW'(base_r + AW'(idx_r));
    a_we      = 1'b0;
    a_waddr   = AW'(base_r + AW'(n_r));
    a_wdata   = {chord_rd[15:8], chord_rd[6:0]};
    a_raddr   = AW'(base_r + AW'(idx_r));
    case (state_r)
      ST_IDLE: begin
        if (accept && in_word.op == OP_TRIGGER && pad_ok) begin
          if (in_word.velocity != 7'd0 && armed_r) begin
            state_nxt = ST_COMMIT_RD;
          end else if (in_word.velocity != 7'd0) begin
            state_nxt = ST_SCAN;
          end else if (act_cnt_r[in_pad] != '0) begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_COMMIT_RD: state_nxt = ST_COMMIT_WR;
      ST_COMMIT_WR: begin
        c_we = 1'b1;
        if (idx_r >= ccnt_r) begin
          c_wdata = {chord_rd[15:8], NOTE_UNUSED};
        end
        state_nxt = (idx_r == SLOTS_C - CW'(1)) ? ST_IDLE : ST_COMMIT_RD;
      end
      ST_SCAN: begin
        a_we = rpend_r && !chord_rd[7];
        if (scan_done) begin
          state_nxt = (n_r != '0) ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_DATA;
      ST_EMIT_DATA: begin
        if (!noff_r && resc_r && max_r > 8'd1) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (dcnt_r == 4'd14) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = last_w ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      chord_mem[c_waddr] <= c_wdata;
    end
    chord_q <= chord_mem[c_raddr];
    cvq     <= cvalid_r[c_raddr];
    if (a_we) begin
      act_mem[a_waddr] <= a_wdata;
    end
    act_q <= act_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        cvalid_r[i] <= 1'b0;
      end
    end else if (c_we) begin
      cvalid_r[c_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r      <= SEL_RESET;
      gch_r      <= 4'd0;
      pend_cnt_r <= 4'd0;
      armed_r    <= 1'b0;
      for (int i = 0; i < SLOTS_PER_PAD; i++) begin
        stage_r[i] <= 16'h0000;
      end
      for (int i = 0; i < PAD_COUNT; i++) begin
        act_cnt_r[i] <= '0;
      end
      idx_r   <= '0;
      n_r     <= '0;
      rpend_r <= 1'b0;
      dcnt_r  <= 4'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_PAD_SEL) begin
          sel_r <= cfg_wdata;
        end else if (cfg_addr == CFG_GLOBAL_CH) begin
          gch_r <= cfg_wdata[3:0];
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_word.op == OP_STAGE) begin
              if (int'(in_word.slot) < SLOTS_PER_PAD) begin
                stage_r[SW'(in_word.slot)] <= {in_word.slot_velocity, in_word.slot_note};
              end
            end else if (in_word.op == OP_ARM) begin
              pend_cnt_r <= in_word.commit_count;
              armed_r    <= 1'b1;
            end else if (in_word.op == OP_TRIGGER && pad_ok) begin
              pad_r     <= in_pad;
              base_r    <= AW'(AW'(in_pad) * AW'(SLOTS_PER_PAD));
              ch_r      <= (in_sel == GLOBAL_SEL) ? gch_r : in_sel[3:0];
              vel_r     <= in_word.velocity;
              rescale_r <= in_word.rescale;
              noff_r    <= (in_word.velocity == 7'd0);
              idx_r     <= '0;
              n_r       <= (in_word.velocity == 7'd0) ? act_cnt_r[in_pad] : '0;
              max_r     <= 8'd0;
              rpend_r   <= 1'b0;
              ccnt_r    <= (int'(pend_cnt_r) > SLOTS_PER_PAD) ? SLOTS_C : CW'(pend_cnt_r);
              if (in_word.velocity != 7'd0 && armed_r) begin
                armed_r <= 1'b0;
              end else if (in_word.velocity == 7'd0) begin
                act_cnt_r[in_pad] <= '0;
              end
            end
          end
        end
        ST_COMMIT_WR: idx_r <= idx_r + CW'(1);
        ST_SCAN: begin
          rpend_r <= (idx_r < SLOTS_C);
          if (idx_r < SLOTS_C) begin
            idx_r <= idx_r + CW'(1);
          end
          if (rpend_r && !chord_rd[7]) begin
            n_r <= n_r + CW'(1);
            if (chord_rd[15:8] > max_r) begin
              max_r <= chord_rd[15:8];
            end
          end
          if (scan_done) begin
            act_cnt_r[pad_r] <= n_r;
            resc_r <= rescale_r && (n_r != '0) && (max_r != {1'b0, vel_r});
            idx_r  <= '0;
          end
        end
        ST_EMIT_DATA: begin
          note_r <= act_q[6:0];
          dcnt_r <= 4'd0;
          rem_r  <= 8'd0;
          if (noff_r) begin
            ovel_r <= 8'd0;
          end else if (!resc_r) begin
            ovel_r <= act_q[14:7];
          end else if (max_r <= 8'd1) begin
            ovel_r <= {1'b0, vel_r};
          end else begin
            num_r <= {7'd0, vclamp - 8'd1} * {8'd0, vel_r - 7'd1};
          end
        end
        ST_DIV: begin
          dcnt_r <= dcnt_r + 4'd1;
          if (rem_sh >= {1'b0, den}) begin
            rem_r <= 8'(rem_sh - {1'b0, den});
            num_r <= {num_r[13:0], 1'b1};
          end else begin
            rem_r <= rem_sh[7:0];
            num_r <= {num_r[13:0], 1'b0};
          end
          if (dcnt_r == 4'd14) begin
            ovel_r <= 8'd1 + (rem_sh >= {1'b0, den} ? {num_r[6:0], 1'b1} : {num_r[6:0], 1'b0});
          end
        end
        ST_OUT: begin
          if (out_ready && !last_w) begin
            idx_r <= idx_r + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  a_out_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("result pending while input open");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (idx_r < n_r)) else $error("emit index past count");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dcnt_r <= 4'd14)) else $error("divider overran");

endmodule
